/* rtl/core/jsu_pkg.sv */
// Shared types, character codes and helpers for the JSON string unescaper.
package jsu_pkg;

    localparam int ResultsMax = 4;
    localparam int HeldDepth  = 3;

    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LOW_N     = 8'h6E;
    localparam logic [7:0] CHAR_LOW_T     = 8'h74;
    localparam logic [7:0] CHAR_LOW_R     = 8'h72;
    localparam logic [7:0] CHAR_LOW_B     = 8'h62;
    localparam logic [7:0] CHAR_LOW_F     = 8'h66;
    localparam logic [7:0] CHAR_LOW_U     = 8'h75;

    localparam logic [7:0] CODE_LF = 8'h0A;
    localparam logic [7:0] CODE_HT = 8'h09;
    localparam logic [7:0] CODE_CR = 8'h0D;
    localparam logic [7:0] CODE_BS = 8'h08;
    localparam logic [7:0] CODE_FF = 8'h0C;

    localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF8_CONT      = 8'h80;
    localparam logic [5:0]  UTF8_CONT_MASK = 6'h3F;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_string;
    } result_t;

    typedef struct packed {
        result_t [ResultsMax-1:0] res;
        logic [2:0]               cnt;
    } bundle_t;

    // {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

/* rtl/core/jsu_in_if.sv */
// Input channel: one text byte per transfer.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_byte;

    modport source (output valid, output in_byte, output first_byte, input ready);
    modport sink   (input valid, input in_byte, input first_byte, output ready);
endinterface

/* rtl/core/jsu_out_if.sv */
// Output channel: one decoded result per transfer.
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid,
                    output end_of_string, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input end_of_string, input last, output ready);
endinterface

/* rtl/core/jsu_decode.sv */
// Parser state and per-byte decode into a bundle of up to four results.
module jsu_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            first_byte,
    output jsu_pkg::bundle_t bundle
);
    import jsu_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [1:0]  hc_reg, hc_next;
    logic [11:0] cp_reg, cp_next;
    logic [7:0]  held_reg [HeldDepth];
    logic        held_we;
    logic        str_take;
    logic [4:0]  hex;
    logic [15:0] cp_full;

    assign hex     = hex_decode(in_byte);
    assign cp_full = {cp_reg, hex[3:0]};

    always_comb
    begin
        mode_next = mode_reg;
        hc_next   = hc_reg;
        cp_next   = cp_reg;
        held_we   = 1'b0;
        str_take  = 1'b0;
        bundle    = '0;

        if (first_byte)
        begin
            hc_next = '0;
            cp_next = '0;
            if (in_byte == CHAR_QUOTE)
            begin
                mode_next = MODE_STR;
            end
            else
            begin
                mode_next = MODE_IDLE;
                bundle.res[0] = '{out_byte: 8'h00, byte_valid: 1'b0, end_of_string: 1'b1};
                bundle.cnt = 3'd1;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDLE: ;
                MODE_STR:  str_take = 1'b1;
                MODE_ESC:
                begin
                    mode_next = MODE_STR;
                    bundle.cnt = 3'd1;
                    bundle.res[0] = '{out_byte: in_byte, byte_valid: 1'b1, end_of_string: 1'b0};
                    unique case (in_byte)
                        CHAR_LOW_N: bundle.res[0].out_byte = CODE_LF;
                        CHAR_LOW_T: bundle.res[0].out_byte = CODE_HT;
                        CHAR_LOW_R: bundle.res[0].out_byte = CODE_CR;
                        CHAR_LOW_B: bundle.res[0].out_byte = CODE_BS;
                        CHAR_LOW_F: bundle.res[0].out_byte = CODE_FF;
                        CHAR_LOW_U:
                        begin
                            mode_next  = MODE_HEX;
                            hc_next    = '0;
                            cp_next    = '0;
                            bundle     = '0;
                        end
                        default: ;
                    endcase
                end
                MODE_HEX:
                begin
                    if (hex[4])
                    begin
                        if (hc_reg == 2'd3)
                        begin
                            // fourth digit: emit the UTF-8 form of the code point
                            hc_next   = '0;
                            cp_next   = '0;
                            mode_next = MODE_STR;
                            if (cp_full < UTF8_ONE_LIMIT)
                            begin
                                bundle.res[0] = '{cp_full[7:0], 1'b1, 1'b0};
                                bundle.cnt = 3'd1;
                            end
                            else if (cp_full < UTF8_TWO_LIMIT)
                            begin
                                bundle.res[0] = '{UTF8_LEAD2 | {3'b000, cp_full[10:6]}, 1'b1, 1'b0};
                                bundle.res[1] = '{UTF8_CONT | {2'b00, cp_full[5:0] & UTF8_CONT_MASK},
                                                  1'b1, 1'b0};
                                bundle.cnt = 3'd2;
                            end
                            else
                            begin
                                bundle.res[0] = '{UTF8_LEAD3 | {4'h0, cp_full[15:12]}, 1'b1, 1'b0};
                                bundle.res[1] = '{UTF8_CONT | {2'b00, cp_full[11:6] & UTF8_CONT_MASK},
                                                  1'b1, 1'b0};
                                bundle.res[2] = '{UTF8_CONT | {2'b00, cp_full[5:0] & UTF8_CONT_MASK},
                                                  1'b1, 1'b0};
                                bundle.cnt = 3'd3;
                            end
                        end
                        else
                        begin
                            held_we = 1'b1;
                            hc_next = hc_reg + 2'd1;
                            cp_next = {cp_reg[7:0], hex[3:0]};
                        end
                    end
                    else
                    begin
                        // broken escape: replay the held digits, then treat byte as plain
                        for (int k = 0; k < HeldDepth; k++)
                        begin
                            if (2'(k) < hc_reg)
                            begin
                                bundle.res[k] = '{held_reg[k], 1'b1, 1'b0};
                            end
                        end
                        bundle.cnt = {1'b0, hc_reg};
                        hc_next    = '0;
                        cp_next    = '0;
                        mode_next  = MODE_STR;
                        str_take   = 1'b1;
                    end
                end
            endcase
        end

        if (str_take)
        begin
            if (in_byte == CHAR_QUOTE)
            begin
                bundle.res[bundle.cnt[1:0]] = '{8'h00, 1'b0, 1'b1};
                bundle.cnt = bundle.cnt + 3'd1;
                mode_next  = MODE_IDLE;
            end
            else if (in_byte == CHAR_BACKSLASH)
            begin
                mode_next = MODE_ESC;
            end
            else
            begin
                bundle.res[bundle.cnt[1:0]] = '{in_byte, 1'b1, 1'b0};
                bundle.cnt = bundle.cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            hc_reg   <= '0;
            cp_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            hc_reg   <= hc_next;
            cp_reg   <= cp_next;
        end
    end

    // held digits: no reset, read only after written
    always_ff @(posedge clk)
    begin
        if (accept && held_we)
        begin
            held_reg[hc_reg] <= in_byte;
        end
    end

endmodule

/* rtl/core/jsu_serialize.sv */
// Result register: holds one bundle and hands it out one result per transfer.
module jsu_serialize (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  jsu_pkg::bundle_t bundle,
    output logic             out_valid,
    input  logic             out_ready,
    output jsu_pkg::result_t out_res,
    output logic             out_last
);
    import jsu_pkg::*;

    result_t [ResultsMax-1:0] res_reg;
    logic [2:0]               rem_reg;
    logic [1:0]               idx_reg;
    logic                     xfer;
    logic                     load;

    assign out_valid = (rem_reg != 3'd0);
    assign out_res   = res_reg[idx_reg];
    assign out_last  = (rem_reg == 3'd1);
    assign xfer      = out_valid && out_ready;
    assign in_ready  = !out_valid || (xfer && out_last);
    assign load      = in_valid && in_ready && (bundle.cnt != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            rem_reg <= bundle.cnt;
            idx_reg <= '0;
        end
        else if (xfer)
        begin
            rem_reg <= rem_reg - 3'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= bundle.res;
        end
    end

endmodule

/* rtl/core/json_string_unescape.sv */
// The first result of a byte is offered in the cycle after its transfer in.
// Throughput: one byte per cycle while each gives at most one result and the output
//   is ready; a byte that gives several results (UTF-8 sequence, digit replay) holds
//   the input until the single result port has drained them from the result register.
// Reset (rst_n low, async): parser idle, result register empty; no clearing pass.
// Top level: JSON string unescaper with \uXXXX to UTF-8 conversion.
module json_string_unescape (
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    in_ch,
    jsu_out_if.source out_ch
);
    import jsu_pkg::*;

    bundle_t bundle;
    result_t out_res;
    logic    accept;
    logic    in_ready;

    // a transfer in updates the parser state and loads the result register if the byte gives results
    assign accept      = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    // decode: state registers plus combinational byte handling
    jsu_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_ch.in_byte),
        .first_byte (in_ch.first_byte),
        .bundle     (bundle)
    );

    // result register; a fresh bundle loads as the last result of the old one leaves
    jsu_serialize u_serialize (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .bundle    (bundle),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (out_res),
        .out_last  (out_ch.last)
    );

    assign out_ch.out_byte      = out_res.out_byte;
    assign out_ch.byte_valid    = out_res.byte_valid;
    assign out_ch.end_of_string = out_res.end_of_string;

endmodule

/* rtl/core/jsu_checker.sv */
// Port-level checks for the unescaper, bound to the top level.
module jsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       end_of_string,
    input logic       last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("stalled result changed");

    // each result is either a byte or an end marker, and the marker closes the burst
    a_eos_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid != end_of_string) && (!end_of_string || last))
        else $error("malformed result");

    // a burst does not break off before its last result
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("burst ended early");

    // input only stalls behind a pending result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with nothing pending");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_byte      (out_ch.out_byte),
    .byte_valid    (out_ch.byte_valid),
    .end_of_string (out_ch.end_of_string),
    .last          (out_ch.last)
);

/* sim/jsu_decode_check.sv */
// Watches both channels, predicts the decoded bytes of each text byte and checks every result.
`timescale 1ns / 1ps

module jsu_decode_check (
    input  logic clk,
    input  logic rst_n,
    jsu_in_if    in_mon,
    jsu_out_if   out_mon,
    output int   errors,
    output int   pending
);
    import jsu_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_string;
        logic       last;
    } decoded_t;

    // Parser copy
    mode_t       mode;
    logic [1:0]  digit_count;
    logic [15:0] code_point;
    logic [7:0]  held_digits [HeldDepth];

    decoded_t    expected_bytes [$];
    int          error_count;
    int          waiting;

    assign errors  = error_count;
    assign pending = waiting;

    task automatic push_decoded(input logic [7:0] b, input logic v, input logic eos);
        decoded_t item;
        item = '{out_byte: b, byte_valid: v, end_of_string: eos, last: 1'b0};
        expected_bytes.insert(expected_bytes.size(), item);
    endtask

    // Byte seen inside a string, outside any escape
    task automatic string_char(input logic [7:0] c);
        if (c == CHAR_QUOTE) begin
            push_decoded(8'h00, 1'b0, 1'b1);
            mode = MODE_IDLE;
        end
        else if (c == CHAR_BACKSLASH) begin
            mode = MODE_ESC;
        end
        else begin
            push_decoded(c, 1'b1, 1'b0);
        end
    endtask

    task automatic decode_text_byte(input logic [7:0] c, input logic first);
        int         start_size;
        logic       is_digit;
        logic [3:0] nibble;
        start_size = expected_bytes.size();
        is_digit   = 1'b0;
        nibble     = 4'h0;
        if (c >= "0" && c <= "9") begin
            is_digit = 1'b1;
            nibble   = c[3:0];
        end
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            is_digit = 1'b1;
            nibble   = c[3:0] + 4'd9;
        end

        if (first) begin
            digit_count = 2'd0;
            code_point  = 16'h0000;
            if (c == CHAR_QUOTE) begin
                mode = MODE_STR;
            end
            else begin
                mode = MODE_IDLE;
                push_decoded(8'h00, 1'b0, 1'b1);
            end
        end
        else begin
            case (mode)
                MODE_STR: string_char(c);
                MODE_ESC:
                begin
                    mode = MODE_STR;
                    case (c)
                        CHAR_LOW_N: push_decoded(CODE_LF, 1'b1, 1'b0);
                        CHAR_LOW_T: push_decoded(CODE_HT, 1'b1, 1'b0);
                        CHAR_LOW_R: push_decoded(CODE_CR, 1'b1, 1'b0);
                        CHAR_LOW_B: push_decoded(CODE_BS, 1'b1, 1'b0);
                        CHAR_LOW_F: push_decoded(CODE_FF, 1'b1, 1'b0);
                        CHAR_LOW_U:
                        begin
                            mode        = MODE_HEX;
                            digit_count = 2'd0;
                            code_point  = 16'h0000;
                        end
                        default: push_decoded(c, 1'b1, 1'b0);
                    endcase
                end
                MODE_HEX:
                begin
                    if (is_digit) begin
                        code_point = {code_point[11:0], nibble};
                        if (digit_count == 2'd3) begin
                            if (code_point < UTF8_ONE_LIMIT) begin
                                push_decoded(code_point[7:0], 1'b1, 1'b0);
                            end
                            else if (code_point < UTF8_TWO_LIMIT) begin
                                push_decoded(UTF8_LEAD2 | code_point[13:6], 1'b1, 1'b0);
                                push_decoded(UTF8_CONT | {2'b00, code_point[5:0]}, 1'b1, 1'b0);
                            end
                            else begin
                                push_decoded(UTF8_LEAD3 | {4'h0, code_point[15:12]}, 1'b1, 1'b0);
                                push_decoded(UTF8_CONT | {2'b00, code_point[11:6]}, 1'b1, 1'b0);
                                push_decoded(UTF8_CONT | {2'b00, code_point[5:0]}, 1'b1, 1'b0);
                            end
                            digit_count = 2'd0;
                            code_point  = 16'h0000;
                            mode        = MODE_STR;
                        end
                        else begin
                            held_digits[digit_count] = c;
                            digit_count = digit_count + 2'd1;
                        end
                    end
                    else begin
                        // broken \u: replay the digits held so far, then treat c as text
                        for (int k = 0; k < int'(digit_count); k++) begin
                            push_decoded(held_digits[k], 1'b1, 1'b0);
                        end
                        digit_count = 2'd0;
                        code_point  = 16'h0000;
                        mode        = MODE_STR;
                        string_char(c);
                    end
                end
                default: mode = MODE_IDLE;
            endcase
        end

        if (expected_bytes.size() > start_size) begin
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        decoded_t got;
        decoded_t want;
        if (!rst_n) begin
            mode        = MODE_IDLE;
            digit_count = 2'd0;
            code_point  = 16'h0000;
            for (int k = 0; k < HeldDepth; k++) begin
                held_digits[k] = 8'h00;
            end
            expected_bytes.delete();
            error_count = 0;
        end
        else begin
            if (out_mon.valid && out_mon.ready) begin
                got = '{out_byte: out_mon.out_byte, byte_valid: out_mon.byte_valid,
                        end_of_string: out_mon.end_of_string, last: out_mon.last};
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result byte=%02h valid=%b eos=%b last=%b",
                             $time, got.out_byte, got.byte_valid, got.end_of_string, got.last);
                    error_count++;
                end
                else begin
                    want = expected_bytes.pop_front();
                    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                        got.end_of_string !== want.end_of_string || got.last !== want.last) begin
                        $display("%0t: mismatch expected %02h/%b/%b/%b got %02h/%b/%b/%b",
                                 $time, want.out_byte, want.byte_valid, want.end_of_string,
                                 want.last, got.out_byte, got.byte_valid, got.end_of_string,
                                 got.last);
                        error_count++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                decode_text_byte(in_mon.in_byte, in_mon.first_byte);
            end
        end
        waiting = expected_bytes.size();
    end

endmodule

/* sim/tb_json_string_unescape.sv */
// Testbench top: drives JSON text bytes into the unescaper and gives the verdict.
`timescale 1ns / 1ps

module tb_json_string_unescape;
    import jsu_pkg::*;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam int TEXT_ITEMS = 270;

    logic clk;
    logic rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    int errors;
    int pending;
    int burst_left;
    int string_items;

    json_string_unescape dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Prediction and comparison live in the checker; the top only makes text.
    jsu_decode_check decode_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_mon  (in_ch),
        .out_mon (out_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("** json_string_unescape: FAILED **");
        $finish;
    end

    // Result side: a random stall style is held for a random stretch, then picked anew. Styles are
    // always ready, mostly ready, mostly stalled, and alternating.
    initial begin : receiver
        int style;
        int left;
        out_ch.ready = 1'b0;
        style = 0;
        left  = 0;
        forever begin
            @(negedge clk);
            if (left == 0) begin
                style = $urandom_range(0, 3);
                left  = $urandom_range(8, 60);
            end
            left--;
            case (style)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= ~out_ch.ready;
            endcase
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) begin
            return {4'h0, nib} + "0";
        end
        return {4'h0, nib} - 8'd10 + (upper ? "A" : "a");
    endfunction

    // One transfer on the text channel. The sender works in bursts; when a
    // burst runs out, valid drops for a random gap (sometimes none). Valid
    // is only lowered at the start of a gap, so back-to-back items in a burst
    // keep it high across the edge.
    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= b;
        in_ch.first_byte <= first;
        burst_left--;
        string_items++;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Stop sending until every predicted result has come back.
    task automatic hold_until_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        burst_left = 0;
    endtask

    // Four-digit \u escape of a code point in random letter case.
    task automatic send_unicode(input logic [15:0] cp);
        send_byte(CHAR_BACKSLASH, 1'b0);
        send_byte(CHAR_LOW_U, 1'b0);
        for (int i = 3; i >= 0; i--) begin
            send_byte(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))), 1'b0);
        end
    endtask

    // One random string value: mostly well formed with random content, plus
    // missing opening quotes, broken \u runs, restarts mid-string, unclosed
    // strings and ignored bytes after the close.
    task automatic put_string();
        int          parts;
        int          kind;
        int          noise;
        logic [7:0]  b;
        logic [7:0]  escapes [8];
        logic [15:0] cp;
        escapes = '{CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH, CHAR_LOW_N,
                    CHAR_LOW_T, CHAR_LOW_R, CHAR_LOW_B, CHAR_LOW_F};

        if ($urandom_range(0, 11) == 0) begin
            // missing opening quote: value ends at once
            do b = 8'($urandom_range(0, 255)); while (b == CHAR_QUOTE);
            send_byte(b, 1'b1);
            return;
        end
        send_byte(CHAR_QUOTE, 1'b1);

        parts = $urandom_range(0, 8);
        repeat (parts) begin
            kind = $urandom_range(0, 19);
            if (kind < 7) begin
                do b = 8'($urandom_range(0, 255));
                while (b == CHAR_QUOTE || b == CHAR_BACKSLASH);
                send_byte(b, 1'b0);
            end
            else if (kind < 12) begin
                send_byte(CHAR_BACKSLASH, 1'b0);
                kind = $urandom_range(0, 8);
                b = (kind < 8) ? escapes[kind] : 8'($urandom_range(0, 255));
                send_byte(b, 1'b0);
            end
            else if (kind < 17) begin
                // spread over the one, two and three byte UTF-8 forms
                case ($urandom_range(0, 3))
                    0:       cp = 16'($urandom_range(0, 16'h007F));
                    1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    default: cp = 16'($urandom_range(0, 16'hFFFF));
                endcase
                send_unicode(cp);
            end
            else if (kind < 19) begin
                // broken \u: zero to three digits, then a non-hex byte
                send_byte(CHAR_BACKSLASH, 1'b0);
                send_byte(CHAR_LOW_U, 1'b0);
                repeat ($urandom_range(0, 3)) begin
                    send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))),
                              1'b0);
                end
                case ($urandom_range(0, 5))
                    0, 1: b = CHAR_QUOTE;
                    2:    b = CHAR_BACKSLASH;
                    default:
                    begin
                        do b = 8'($urandom_range(0, 255));
                        while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                               (b >= "A" && b <= "F"));
                    end
                endcase
                send_byte(b, 1'b0);
            end
            else begin
                // restart in the middle of a string
                b = ($urandom_range(0, 1) == 0) ? CHAR_QUOTE : 8'($urandom_range(0, 255));
                send_byte(b, 1'b1);
            end
        end

        if ($urandom_range(0, 7) != 0) begin
            send_byte(CHAR_QUOTE, 1'b0);
            // bytes between values are ignored
            noise = $urandom_range(0, 2);
            repeat (noise) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    initial begin : stimulus
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = 8'h00;
        in_ch.first_byte = 1'b0;
        burst_left       = 0;
        string_items     = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part
        send_byte("A", 1'b1);                 // no opening quote
        send_byte(CHAR_QUOTE, 1'b1);
        send_byte(8'h00, 1'b0);               // byte extremes pass through
        send_byte(8'hFF, 1'b0);
        send_byte(CHAR_BACKSLASH, 1'b0);
        send_byte(CHAR_LOW_N, 1'b0);
        send_unicode(16'h0000);               // code point zero gives a valid 0x00
        send_byte(CHAR_BACKSLASH, 1'b0);      // top code point, mixed case digits
        send_byte(CHAR_LOW_U, 1'b0);
        send_byte("F", 1'b0);
        send_byte("f", 1'b0);
        send_byte("f", 1'b0);
        send_byte("F", 1'b0);
        send_byte(CHAR_BACKSLASH, 1'b0);      // three digits, then a closing quote:
        send_byte(CHAR_LOW_U, 1'b0);          // replay plus end of string, four results
        send_byte("1", 1'b0);
        send_byte("2", 1'b0);
        send_byte("3", 1'b0);
        send_byte(CHAR_QUOTE, 1'b0);
        send_byte("Z", 1'b0);                 // outside a string: ignored
        send_byte(CHAR_QUOTE, 1'b1);
        send_byte(CHAR_BACKSLASH, 1'b0);
        send_byte(CHAR_QUOTE, 1'b1);          // restart while inside an escape
        send_byte(CHAR_QUOTE, 1'b0);

        hold_until_drained();

        // Random part
        while (string_items < TEXT_ITEMS) begin
            put_string();
            if ($urandom_range(0, 24) == 0) begin
                hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (8) @(negedge clk);

        if (errors == 0 && pending == 0) begin
            $display("** json_string_unescape: PASSED **");
        end
        else begin
            $display("** json_string_unescape: FAILED **");
        end
        $finish;
    end

endmodule
